>>> rtl/core/rss_pkg.sv
// Shared types, tag constants and a helper for the save signature scan unit.
package rss_pkg;

    // One input item and one result item
    typedef struct packed {
        logic [31:0] rom_word;
        logic        is_last;
    } t_in;

    typedef struct packed {
        logic [1:0]  save_kind;
        logic [17:0] flash_bytes;
        logic        rtc_present;
    } t_out;

    // Detected kind while scanning
    typedef enum logic [2:0] {
        KIND_NOTHING = 3'd0,
        KIND_EEPROM  = 3'd1,
        KIND_SRAM    = 3'd2,
        KIND_FLASH   = 3'd3,
        KIND_GFLASH  = 3'd4
    } t_kind;

    // Flash size codes
    localparam logic [1:0] SIZE_32K  = 2'd0;
    localparam logic [1:0] SIZE_64K  = 2'd1;
    localparam logic [1:0] SIZE_128K = 2'd2;

    // Reported save kinds
    localparam logic [1:0] SAVE_EEPROM = 2'd0;
    localparam logic [1:0] SAVE_SRAM   = 2'd1;
    localparam logic [1:0] SAVE_FLASH  = 2'd2;
    localparam logic [1:0] SAVE_NONE   = 2'd3;

    // Backup sizes in bytes
    localparam logic [17:0] BYTES_32K  = 18'h08000;
    localparam logic [17:0] BYTES_64K  = 18'h10000;
    localparam logic [17:0] BYTES_128K = 18'h20000;

    // Scan state carried from one position check to the next
    typedef struct packed {
        t_kind      kind;
        logic [1:0] size;
        logic       rtc;
    } t_scan_st;

    localparam t_scan_st SCAN_ST_RESET = '{kind: KIND_NOTHING, size: SIZE_64K, rtc: 1'b0};

    // Tags, byte zero in bits 7:0
    localparam logic [71:0] TAG_EEPROM   = 72'h00_00_5F4D4F_52504545;
    localparam logic [71:0] TAG_SRAM     = 72'h00_000000_5F_4D415253;
    localparam logic [71:0] TAG_FLASH1M  = 72'h00_5F4D3148_53414C46;
    localparam logic [71:0] TAG_FLASH512 = 72'h5F_32313548_53414C46;
    localparam logic [71:0] TAG_FLASH    = 72'h00_000000_48_53414C46;
    localparam logic [71:0] TAG_RTC      = 72'h00_565F4354_52494953;

    localparam logic [3:0] LEN_EEPROM   = 4'd7;
    localparam logic [3:0] LEN_SRAM     = 4'd5;
    localparam logic [3:0] LEN_FLASH1M  = 4'd8;
    localparam logic [3:0] LEN_FLASH512 = 4'd9;
    localparam logic [3:0] LEN_FLASH    = 4'd5;
    localparam logic [3:0] LEN_RTC      = 4'd8;

    // Compare the first len bytes of a 12-byte window with a tag
    function automatic logic tag_hit(input logic [95:0] bytes, input logic [71:0] tag,
                                     input logic [3:0] len);
        logic hit;
        hit = 1'b1;
        for (int i = 0; i < 9; i++) begin
            if ((4'(i) < len) && (bytes[8*i +: 8] != tag[8*i +: 8])) begin
                hit = 1'b0;
            end
        end
        return hit;
    endfunction

endpackage

>>> rtl/core/rss_check.sv
// One position check: tag compare and priority update of the scan state.
module rss_check (
    input  logic [95:0]       i_bytes,
    input  logic              i_has8,
    input  logic              i_has12,
    input  rss_pkg::t_scan_st i_st,
    output rss_pkg::t_scan_st o_st
);
    import rss_pkg::*;

    logic hit_eeprom;
    logic hit_sram;
    logic hit_flash1m;
    logic hit_flash512;
    logic hit_flash;
    logic hit_rtc;

    // Tag matches; a tag running past the available bytes never matches
    assign hit_eeprom   = i_has8  && tag_hit(i_bytes, TAG_EEPROM,   LEN_EEPROM);
    assign hit_sram     = i_has8  && tag_hit(i_bytes, TAG_SRAM,     LEN_SRAM);
    assign hit_flash1m  = i_has8  && tag_hit(i_bytes, TAG_FLASH1M,  LEN_FLASH1M);
    assign hit_flash512 = i_has12 && tag_hit(i_bytes, TAG_FLASH512, LEN_FLASH512);
    assign hit_flash    = i_has8  && tag_hit(i_bytes, TAG_FLASH,    LEN_FLASH);
    assign hit_rtc      = i_has8  && tag_hit(i_bytes, TAG_RTC,      LEN_RTC);

    // First matching tag wins, then the kind decides whether it takes effect
    always_comb begin
        o_st = i_st;
        if (hit_eeprom) begin
            if (i_st.kind inside {KIND_NOTHING, KIND_GFLASH}) begin
                o_st.kind = KIND_EEPROM;
            end
        end else if (hit_sram) begin
            if (i_st.kind inside {KIND_NOTHING, KIND_EEPROM, KIND_GFLASH}) begin
                o_st.kind = KIND_SRAM;
                o_st.size = SIZE_32K;
            end
        end else if (hit_flash1m) begin
            if (i_st.kind == KIND_NOTHING) begin
                o_st.kind = KIND_FLASH;
                o_st.size = SIZE_128K;
            end
        end else if (hit_flash512) begin
            if (i_st.kind == KIND_NOTHING) begin
                o_st.kind = KIND_FLASH;
                o_st.size = SIZE_64K;
            end
        end else if (hit_flash) begin
            if (i_st.kind == KIND_NOTHING) begin
                o_st.kind = KIND_GFLASH;
                o_st.size = SIZE_64K;
            end
        end else if (hit_rtc) begin
            o_st.rtc = 1'b1;
        end
    end

endmodule

>>> rtl/core/rss_scan.sv
// Word window, scan state registers and result formatting.
module rss_scan (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_step,
    input  logic [31:0]   i_word,
    input  logic          i_last,
    output rss_pkg::t_out o_res
);
    import rss_pkg::*;

    logic [31:0] r_win0;
    logic [31:0] r_win1;
    logic [1:0]  r_fill;
    t_scan_st    r_st;

    logic [31:0] n_win0;
    logic [31:0] n_win1;
    logic [1:0]  n_fill;
    t_scan_st    n_st;

    logic        full;
    logic        two;
    logic [31:0] buf0;
    logic [31:0] buf1;
    logic [31:0] buf2;
    t_scan_st    st_a;
    t_scan_st    st_b;

    // Assemble the window: stored words followed by the new word
    assign full = (r_fill >= 2'd2);
    assign two  = (r_fill == 2'd1);
    assign buf0 = (r_fill == 2'd0) ? i_word : r_win0;
    assign buf1 = full ? r_win1 : (two ? i_word : 32'h0);
    assign buf2 = full ? i_word : 32'h0;

    // Check at the window head, and on the last item the next position too
    rss_check u_check_a (
        .i_bytes (96'({buf2, buf1, buf0})),
        .i_has8  (full || two),
        .i_has12 (full),
        .i_st    (r_st),
        .o_st    (st_a)
    );

    rss_check u_check_b (
        .i_bytes (96'({32'h0, buf2, buf1})),
        .i_has8  (full),
        .i_has12 (1'b0),
        .i_st    (st_a),
        .o_st    (st_b)
    );

    // Next window and state
    always_comb begin
        n_win0 = r_win0;
        n_win1 = r_win1;
        n_fill = r_fill;
        n_st   = r_st;
        if (i_step) begin
            if (i_last) begin
                n_win0 = 32'h0;
                n_win1 = 32'h0;
                n_fill = 2'd0;
                n_st   = SCAN_ST_RESET;
            end else if (full) begin
                n_win0 = buf1;
                n_win1 = buf2;
                n_fill = 2'd2;
                n_st   = st_a;
            end else begin
                n_win0 = buf0;
                n_win1 = buf1;
                n_fill = two ? 2'd2 : 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win0 <= 32'h0;
            r_win1 <= 32'h0;
            r_fill <= 2'd0;
            r_st   <= SCAN_ST_RESET;
        end else begin
            r_win0 <= n_win0;
            r_win1 <= n_win1;
            r_fill <= n_fill;
            r_st   <= n_st;
        end
    end

    // Result fields from the final state
    always_comb begin
        case (st_b.kind)
            KIND_EEPROM: o_res.save_kind = SAVE_EEPROM;
            KIND_SRAM:   o_res.save_kind = SAVE_SRAM;
            KIND_FLASH:  o_res.save_kind = SAVE_FLASH;
            KIND_GFLASH: o_res.save_kind = SAVE_FLASH;
            default:     o_res.save_kind = SAVE_NONE;
        endcase
        case (st_b.size)
            SIZE_32K:  o_res.flash_bytes = BYTES_32K;
            SIZE_128K: o_res.flash_bytes = BYTES_128K;
            default:   o_res.flash_bytes = BYTES_64K;
        endcase
        o_res.rtc_present = st_b.rtc;
    end

    // The window never claims three words
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill != 2'd3)
        else $error("window fill out of range");

    // A last item leaves the scan in its reset state
    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last) |=> (r_fill == 2'd0 && r_st == SCAN_ST_RESET))
        else $error("scan state not cleared after last item");

endmodule

>>> rtl/core/rom_save_signature_scan_unit.sv
// Top level of the save signature scan unit: input register, scan, result register.
//
// Takes a cartridge image as 32-bit little-endian words, one item per cycle, and
// looks for the save-type tags at every word-aligned position using a three-word
// window. One result (save kind, flash size, RTC flag) is registered once the item
// marked last leaves the input register; all other items produce nothing. Sustained
// rate is one item per cycle: the tag compare and priority update for a word sit
// between the input register and the window/state registers. An input item marked
// last waits in the input register only while a previous result is held by a stalled
// output. After the result the unit is back in its reset state for the next image.
module rom_save_signature_scan_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  rss_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output rss_pkg::t_out o_out_data
);
    import rss_pkg::*;

    logic r_in_valid;
    t_in  r_in;
    logic r_out_valid;
    t_out r_out;

    logic n_in_valid;
    logic n_out_valid;

    logic accept;
    logic adv;
    logic step;
    t_out res;

    // Handshake: a held item moves on unless it needs a busy result register
    assign adv        = !r_in.is_last || !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !adv;
    assign accept     = i_in_valid && !o_in_stall;
    assign step       = r_in_valid && adv;

    // Input register
    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (adv) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in_data;
        end
    end

    // Window, tag checks and scan state
    rss_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_word  (r_in.rom_word),
        .i_last  (r_in.is_last),
        .o_res   (res)
    );

    // Result register
    always_comb begin
        n_out_valid = r_out_valid;
        if (step && r_in.is_last) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && r_in.is_last) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A result appears only after a last item left the input register
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_in_valid && r_in.is_last))
        else $error("result without a last item");

    // A last item never overwrites a stalled result
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && r_in_valid && r_in.is_last) |-> o_in_stall)
        else $error("last item advanced over a stalled result");

    // Reported size is always one of the three backup sizes
    a_size_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.flash_bytes == BYTES_32K || r_out.flash_bytes == BYTES_64K
                         || r_out.flash_bytes == BYTES_128K))
        else $error("illegal flash size in result");

endmodule

>>> dv/rom_save_signature_scan_unit_tb.sv
// Self-checking testbench for the save signature scan unit: directed table, random images.
module rom_save_signature_scan_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rss_pkg::*;

    localparam int RANDOM_WORDS = 1750;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 20;
    localparam int REPORT_MAX   = 10;

    // Signature tags looked for in the image
    typedef enum int {
        SIG_EEPROM, SIG_SRAM, SIG_FLASH1M, SIG_FLASH512, SIG_FLASH, SIG_RTC, SIG_COUNT
    } t_sig_id;

    string sig_text [SIG_COUNT] = '{"EEPROM_", "SRAM_", "FLASH1M_", "FLASH512_", "FLASH",
                                    {"SIIRTC", "_V"}};

    // One row of the directed table; want is used only where typed is set
    typedef struct packed {
        logic [31:0] word;
        logic        last;
        logic        typed;
        t_out        want;
    } t_directed_row;

    logic  i_clk;
    logic  i_rst_n     = 1'b0;
    logic  i_in_valid  = 1'b0;
    logic  o_in_stall;
    t_in   i_in_data   = '0;
    logic  o_out_valid;
    logic  i_out_stall = 1'b0;
    t_out  o_out_data;

    rom_save_signature_scan_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Scan state of the predictor
    logic [31:0] win_words [2];
    logic [1:0]  win_fill;
    t_kind       scan_kind;
    logic [1:0]  scan_size;
    logic        scan_rtc;

    t_out expected_signatures [$];
    logic [31:0] image_words [$];

    int  fail_count  = 0;
    int  cycle_count = 0;
    int  burst_left  = 0;
    bit  no_gaps     = 1'b0;
    bit  hold_req    = 1'b0;
    int  hold_left   = 0;
    int  stall_mode  = 0;
    int  mode_left   = 0;

    task automatic scan_reset();
        win_words[0] = '0;
        win_words[1] = '0;
        win_fill     = '0;
        scan_kind    = KIND_NOTHING;
        scan_size    = SIZE_64K;
        scan_rtc     = 1'b0;
    endtask

    // A tag only counts when all of its bytes are inside the image
    function automatic bit tag_found(input logic [95:0] bytes, input int avail,
                                     input string tag);
        if (tag.len() > avail) return 1'b0;
        for (int i = 0; i < tag.len(); i++) begin
            if (bytes[8*i +: 8] != tag[i]) return 1'b0;
        end
        return 1'b1;
    endfunction

    // Priority update at one word-aligned position
    task automatic check_position(input logic [95:0] bytes, input int avail);
        t_kind k;
        k = scan_kind;
        if (tag_found(bytes, avail, sig_text[SIG_EEPROM])) begin
            if (k == KIND_NOTHING || k == KIND_GFLASH) scan_kind = KIND_EEPROM;
        end else if (tag_found(bytes, avail, sig_text[SIG_SRAM])) begin
            if (k == KIND_NOTHING || k == KIND_EEPROM || k == KIND_GFLASH) begin
                scan_kind = KIND_SRAM;
                scan_size = SIZE_32K;
            end
        end else if (tag_found(bytes, avail, sig_text[SIG_FLASH1M])) begin
            if (k == KIND_NOTHING) begin
                scan_kind = KIND_FLASH;
                scan_size = SIZE_128K;
            end
        end else if (tag_found(bytes, avail, sig_text[SIG_FLASH512])) begin
            if (k == KIND_NOTHING) begin
                scan_kind = KIND_FLASH;
                scan_size = SIZE_64K;
            end
        end else if (tag_found(bytes, avail, sig_text[SIG_FLASH])) begin
            if (k == KIND_NOTHING) begin
                scan_kind = KIND_GFLASH;
                scan_size = SIZE_64K;
            end
        end else if (tag_found(bytes, avail, sig_text[SIG_RTC])) begin
            scan_rtc = 1'b1;
        end
    endtask

    // Advance the scan by one word; a word marked last flushes and yields the signature
    task automatic predict_signature(input t_in item, output bit has_res, output t_out res);
        logic [31:0] win_buf [3];
        logic [95:0] bytes;
        int n;
        n = (win_fill > 2'd2) ? 2 : int'(win_fill);
        win_buf[0] = win_words[0];
        win_buf[1] = win_words[1];
        win_buf[2] = '0;
        win_buf[n] = item.rom_word;
        n++;
        has_res = 1'b0;
        res     = '0;
        if (!item.is_last) begin
            if (n == 3) begin
                check_position({win_buf[2], win_buf[1], win_buf[0]}, 12);
                win_buf[0] = win_buf[1];
                win_buf[1] = win_buf[2];
                n = 2;
            end
            win_words[0] = win_buf[0];
            win_words[1] = (n > 1) ? win_buf[1] : '0;
            win_fill     = 2'(n);
        end else begin
            for (int i = 0; i < n; i++) begin
                bytes = '0;
                for (int j = i; j < n; j++) bytes[32*(j-i) +: 32] = win_buf[j];
                check_position(bytes, (n - i) * 4);
            end
            case (scan_kind)
                KIND_EEPROM:             res.save_kind = SAVE_EEPROM;
                KIND_SRAM:               res.save_kind = SAVE_SRAM;
                KIND_FLASH, KIND_GFLASH: res.save_kind = SAVE_FLASH;
                default:                 res.save_kind = SAVE_NONE;
            endcase
            case (scan_size)
                SIZE_32K:  res.flash_bytes = BYTES_32K;
                SIZE_128K: res.flash_bytes = BYTES_128K;
                default:   res.flash_bytes = BYTES_64K;
            endcase
            res.rtc_present = scan_rtc;
            has_res = 1'b1;
            scan_reset();
        end
    endtask

    task automatic note_failure(input string what, input t_out want, input t_out got);
        fail_count++;
        if (fail_count <= REPORT_MAX) begin
            $display("%0t: %s: expected kind %0d bytes %0d rtc %0d, %s %0d bytes %0d rtc %0d",
                     $realtime, what, want.save_kind, want.flash_bytes, want.rtc_present,
                     "got kind", got.save_kind, got.flash_bytes, got.rtc_present);
        end
    endtask

    task automatic check_signature(input t_out got);
        t_out want;
        if (expected_signatures.size() == 0) begin
            note_failure("result with nothing pending", '0, got);
            return;
        end
        want = expected_signatures.pop_front();
        if (got.save_kind != want.save_kind) note_failure("save_kind", want, got);
        else if (got.flash_bytes != want.flash_bytes) note_failure("flash_bytes", want, got);
        else if (got.rtc_present != want.rtc_present) note_failure("rtc_present", want, got);
    endtask

    // Offer one item, bursts separated by random gaps unless no_gaps is set; predict once accepted
    task automatic push_item(input t_in item, input bit typed, input t_out want);
        bit   has_res;
        t_out predicted;
        if (burst_left == 0 && !no_gaps) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
        if (burst_left > 0) burst_left--;
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_signature(item, has_res, predicted);
        if (has_res) expected_signatures.push_back(typed ? want : predicted);
    endtask

    // Sender pauses until every pending signature has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_signatures.size() != 0) @(posedge i_clk);
        burst_left = 0;
    endtask

    // Random image: tags, near misses and noise; the cut may split a tag at the end
    task automatic build_image(input int max_len);
        int len, pick, nwords, idx;
        t_sig_id sig;
        logic [31:0] w;
        image_words.delete();
        pick = $urandom_range(0, 99);
        if (pick < 80)      len = $urandom_range(1, 10);
        else if (pick < 95) len = $urandom_range(11, 30);
        else                len = $urandom_range(31, 64);
        if (len > max_len) len = max_len;
        while (image_words.size() < len) begin
            pick = $urandom_range(0, 9);
            sig  = t_sig_id'($urandom_range(0, SIG_COUNT - 1));
            if (pick <= 5) begin
                nwords = (sig_text[sig].len() + 3) / 4;
                for (int k = 0; k < nwords; k++) begin
                    w = $urandom;
                    for (int b = 0; b < 4; b++) begin
                        idx = 4 * k + b;
                        if (idx < sig_text[sig].len()) w[8*b +: 8] = sig_text[sig][idx];
                    end
                    image_words.push_back(w);
                end
            end else if (pick == 6) begin
                for (int b = 0; b < 4; b++) w[8*b +: 8] = sig_text[sig][b];
                w[$urandom_range(0, 31)] ^= 1'b1;
                image_words.push_back(w);
            end else if (pick == 7) begin
                image_words.push_back($urandom_range(0, 1) ? 32'h0 : 32'hFFFF_FFFF);
            end else begin
                image_words.push_back($urandom);
            end
        end
        while (image_words.size() > len) void'(image_words.pop_back());
    endtask

    task automatic send_image();
        t_in item;
        foreach (image_words[i]) begin
            item.rom_word = image_words[i];
            item.is_last  = (i == image_words.size() - 1);
            push_item(item, 1'b0, '0);
        end
    endtask

    // Receiver: checks accepted results, stalls in modes, long hold-off on request
    always @(posedge i_clk) begin
        if (o_out_valid && !i_out_stall) check_signature(o_out_data);
        if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(5, 60);
            end else begin
                mode_left--;
            end
            case (stall_mode)
                0:       i_out_stall <= 1'b0;
                1:       i_out_stall <= ($urandom_range(0, 3) == 0);
                2:       i_out_stall <= 1'($urandom_range(0, 1));
                default: i_out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Main sequence
    initial begin
        t_directed_row directed_rows [23];
        t_in item;
        int  random_words;
        int  image_count;
        directed_rows = '{
            // empty one-word images, extremes of the word
            '{32'h0000_0000, 1'b1, 1'b1, '{SAVE_NONE,   BYTES_64K,  1'b0}},
            '{32'hFFFF_FFFF, 1'b1, 1'b1, '{SAVE_NONE,   BYTES_64K,  1'b0}},
            // EEPROM_
            '{32'h5250_4545, 1'b0, 1'b0, '0},
            '{32'h005F_4D4F, 1'b0, 1'b0, '0},
            '{32'h0000_0000, 1'b1, 1'b1, '{SAVE_EEPROM, BYTES_64K,  1'b0}},
            // SRAM_ ending on the last word
            '{32'h4D41_5253, 1'b0, 1'b0, '0},
            '{32'h0000_005F, 1'b1, 1'b1, '{SAVE_SRAM,   BYTES_32K,  1'b0}},
            // FLASH1M_
            '{32'h5341_4C46, 1'b0, 1'b0, '0},
            '{32'h5F4D_3148, 1'b0, 1'b0, '0},
            '{32'h0000_0000, 1'b1, 1'b1, '{SAVE_FLASH,  BYTES_128K, 1'b0}},
            // FLASH512_ using the full window at the end
            '{32'h5341_4C46, 1'b0, 1'b0, '0},
            '{32'h3231_3548, 1'b0, 1'b0, '0},
            '{32'h0000_005F, 1'b1, 1'b1, '{SAVE_FLASH,  BYTES_64K,  1'b0}},
            // generic FLASH
            '{32'h5341_4C46, 1'b0, 1'b0, '0},
            '{32'h0000_0048, 1'b1, 1'b0, '0},
            // RTC tag alone
            '{32'h5249_4953, 1'b0, 1'b0, '0},
            '{32'h565F_4354, 1'b1, 1'b1, '{SAVE_NONE,   BYTES_64K,  1'b1}},
            // FLASH512_ cut short by the end of the image
            '{32'h5341_4C46, 1'b0, 1'b0, '0},
            '{32'h3231_3548, 1'b1, 1'b0, '0},
            // generic flash later overridden by SRAM_
            '{32'h5341_4C46, 1'b0, 1'b0, '0},
            '{32'h0000_0048, 1'b0, 1'b0, '0},
            '{32'h4D41_5253, 1'b0, 1'b0, '0},
            '{32'h0000_005F, 1'b1, 1'b0, '0}
        };
        scan_reset();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r]) begin
            item.rom_word = directed_rows[r].word;
            item.is_last  = directed_rows[r].last;
            push_item(item, directed_rows[r].typed, directed_rows[r].want);
        end
        drain_results();

        random_words = 0;
        image_count  = 0;
        while (random_words < RANDOM_WORDS) begin
            // long receiver hold-off while short images keep arriving back to back
            if (image_count == 60) begin
                hold_req = 1'b1;
                no_gaps  = 1'b1;
            end
            if (image_count == 80) no_gaps = 1'b0;
            if (image_count % 45 == 44) drain_results();
            build_image((image_count >= 60 && image_count < 80) ? 3 : 64);
            random_words += image_words.size();
            send_image();
            image_count++;
        end

        i_in_valid <= 1'b0;
        while (expected_signatures.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
